/* src/pra_pkg.sv */
// shared types and constants of the pulse rate anemometer
package pra_pkg;

  // item operation codes
  localparam logic OP_PIN   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register select (byte address bit 2)
  localparam logic REG_SPEED_MULT = 1'b0;
  localparam logic REG_DEBOUNCE   = 1'b1;

  localparam logic [15:0] SPEED_MULT_RST = 16'd256;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd500;

  // 500000 Hz*us in q16.16 = 32768000000
  localparam int unsigned NUM_W = 35;
  localparam logic [NUM_W-1:0] RATE_NUM = 35'h7_A120_0000;

  // periods below this give a quotient above 32 bits
  localparam logic [31:0] MIN_PERIOD = 32'd8;

  localparam logic [31:0] RATE_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] speed_mult;
    logic [15:0] debounce_us;
  } pra_cfg_t;

endpackage

/* src/pra_if.sv */
// valid/ready channels carrying input and result words
interface pra_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] time_us;
  logic        pin_level;

  modport source (output valid, output op, output time_us, output pin_level, input ready);
  modport sink   (input valid, input op, input time_us, input pin_level, output ready);
endinterface

interface pra_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed;
  logic        stalled;
  logic [31:0] pulse_total;
  logic [31:0] bounce_total;

  modport source (output valid, output speed, output stalled, output pulse_total,
                  output bounce_total, input ready);
  modport sink   (input valid, input speed, input stalled, input pulse_total,
                  input bounce_total, output ready);
endinterface

/* src/pra_regs.sv */
// apb configuration registers
module pra_regs import pra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output pra_cfg_t    cfg_o
);

  pra_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_mult  <= SPEED_MULT_RST;
      cfg_q.debounce_us <= DEBOUNCE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SPEED_MULT: cfg_q.speed_mult  <= pwdata[15:0];
        REG_DEBOUNCE:   cfg_q.debounce_us <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SPEED_MULT: prdata = {16'd0, cfg_q.speed_mult};
      REG_DEBOUNCE:   prdata = {16'd0, cfg_q.debounce_us};
    endcase
  end

endmodule

/* src/pra_div.sv */
// radix-2 restoring divider of the fixed rate numerator by a period
module pra_div import pra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic             busy_q;
  logic             done_q;
  logic [5:0]       cnt_q;
  logic [31:0]      rem_q;
  logic [31:0]      den_q;
  logic [NUM_W-1:0] quot_q;
  logic [32:0]      rem_sh;
  logic [33:0]      trial;
  logic             ge;

  // shift in the next numerator bit and try the subtract
  assign rem_sh = {rem_q, RATE_NUM[cnt_q]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = ~trial[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= '0;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? trial[31:0] : rem_sh[31:0];
      quot_q <= {quot_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  // divisor is at least MIN_PERIOD, so the quotient fits 32 bits
  assign quot_o = quot_q[31:0];

endmodule

/* src/pulse_rate_anemometer_unit.sv */
// top level of the reed switch anemometer: sequencer, state and shared multiplier
//
//  channel   dir  handshake        payload
//  in_i      in   valid/ready      op, time_us, pin_level
//  out_o     out  valid/ready      speed, stalled, pulse_total, bounce_total
//  apb       in   psel/penable     paddr, pwdata -> prdata (pready tied high)
//
// a rising edge, the arming edge or a bounce is settled in the decide state; a counted
// edge and a query run the 35-step serial divide of the rate numerator by the period
// (periods under 8 us skip it and saturate)
// in_i.ready is high only while the sequencer is idle; one result word waits in
// the output register, so the next item may enter while it is still unread
// a query that finishes while that register is still full holds until it drains
// reset restores the register defaults and the waiting-for-first-edge state
module pulse_rate_anemometer_unit import pra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pra_in_if.sink      in_i,
  pra_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_SPD    = 3'd5;

  pra_cfg_t cfg;

  logic [2:0]  state_q, state_d;

  // latched item
  logic        op_q;
  logic        level_q;
  logic [31:0] time_q;

  // block state
  logic [31:0] avg_q, avg_d;
  logic [31:0] last_q, last_d;
  logic        armed_q, armed_d;
  logic [31:0] pulse_q, pulse_d;
  logic [31:0] bounce_q, bounce_d;

  // working registers
  logic [31:0] rate_q, rate_d;
  logic [47:0] prod_q;
  logic [31:0] mul_a;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] speed_q, speed_d;
  logic        stalled_q, stalled_d;
  logic [31:0] pt_q, bt_q;
  logic        out_load;

  logic        in_fire;
  logic [31:0] diff;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quot;
  logic        slot_free;
  logic [32:0] avg_sum;

  pra_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pra_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (diff),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;

  // elapsed time since the last accepted edge, modulo 2^32
  assign diff      = time_q - last_q;
  assign slot_free = ~out_valid_q | out_o.ready;
  assign avg_sum   = {1'b0, avg_q} + {1'b0, rate_q};

  // shared 32x16 multiplier: rate for the stall test (kept while a stalled
  // word waits for the output register), then the average
  assign mul_a = (state_q == S_APPLY || (state_q == S_CHECK && prod_q[47:24] == 24'd0))
               ? rate_q : avg_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 48'(mul_a) * 48'(cfg.speed_mult);
  end

  always_comb begin
    state_d     = state_q;
    avg_d       = avg_q;
    last_d      = last_q;
    armed_d     = armed_q;
    pulse_d     = pulse_q;
    bounce_d    = bounce_q;
    rate_d      = rate_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    speed_d     = speed_q;
    stalled_d   = stalled_q;
    out_valid_d = out_valid_q & ~out_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (op_q == OP_PIN && level_q) begin
          // rising edge changes nothing
          state_d = S_IDLE;
        end else if (op_q == OP_PIN && armed_q) begin
          last_d  = time_q;
          armed_d = 1'b0;
          state_d = S_IDLE;
        end else if (op_q == OP_PIN && diff < {16'd0, cfg.debounce_us}) begin
          bounce_d = bounce_q + 32'd1;
          state_d  = S_IDLE;
        end else begin
          if (op_q == OP_PIN) begin
            pulse_d = pulse_q + 32'd1;
          end
          if (diff < MIN_PERIOD) begin
            rate_d  = RATE_SAT;
            state_d = S_APPLY;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          rate_d  = div_quot;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (op_q == OP_PIN) begin
          // average the new rate with the running average, no overflow
          avg_d   = avg_sum[32:1];
          last_d  = time_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // product is q24.24, stall below 1.0
        if (prod_q[47:24] == 24'd0) begin
          if (slot_free) begin
            armed_d     = 1'b1;
            out_load    = 1'b1;
            speed_d     = '0;
            stalled_d   = 1'b1;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          state_d = S_SPD;
        end
      end
      S_SPD: begin
        if (slot_free) begin
          out_load    = 1'b1;
          speed_d     = (prod_q[47:40] != 8'd0) ? RATE_SAT : prod_q[39:8];
          stalled_d   = 1'b0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      avg_q       <= '0;
      last_q      <= '0;
      armed_q     <= 1'b1;
      pulse_q     <= '0;
      bounce_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      avg_q       <= avg_d;
      last_q      <= last_d;
      armed_q     <= armed_d;
      pulse_q     <= pulse_d;
      bounce_q    <= bounce_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
    if (in_fire) begin
      op_q    <= in_i.op;
      time_q  <= in_i.time_us;
      level_q <= in_i.pin_level;
    end
    if (out_load) begin
      speed_q   <= speed_d;
      stalled_q <= stalled_d;
      pt_q      <= pulse_q;
      bt_q      <= bounce_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.speed        = speed_q;
  assign out_o.stalled      = stalled_q;
  assign out_o.pulse_total  = pt_q;
  assign out_o.bounce_total = bt_q;

endmodule

/* tb/pulse_rate_anemometer_unit_tb.sv */
// self-checking testbench of the reed switch anemometer unit
`timescale 1ns / 100ps

module pulse_rate_anemometer_unit_tb;
  import pra_pkg::*;

  // predicts every speed word of the anemometer and checks the words that come back
  class anemo_scoreboard;
    typedef struct packed {
      logic [31:0] speed;
      logic        stalled;
      logic [31:0] pulse_total;
      logic [31:0] bounce_total;
    } reading_t;

    logic [15:0] mult;
    logic [15:0] deb;
    logic [31:0] avg_hz;
    logic [31:0] last_edge;
    logic [31:0] pulses;
    logic [31:0] bounces;
    bit          waiting;
    reading_t    readings_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      reset_state();
    endfunction

    function void reset_state();
      mult      = SPEED_MULT_RST;
      deb       = DEBOUNCE_RST;
      avg_hz    = '0;
      last_edge = '0;
      pulses    = '0;
      bounces   = '0;
      waiting   = 1'b1;
      readings_q.delete();
    endfunction

    function void set_reg(logic sel, logic [15:0] val);
      if (sel == REG_SPEED_MULT) mult = val;
      else deb = val;
    endfunction

    // q16.16 rotation rate of one period, 500000/period hz
    function logic [31:0] hz_of_period(logic [31:0] period);
      logic [63:0] q;
      if (period == 0) return 32'hFFFF_FFFF;
      q = 64'd32768000000 / {32'd0, period};
      if (q > 64'h0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
      return q[31:0];
    endfunction

    function void note_input(logic op, logic [31:0] t, logic lvl);
      logic [31:0] diff;
      logic [63:0] now_speed;
      logic [63:0] spd;
      reading_t    r;
      diff = t - last_edge;
      if (op == OP_PIN) begin
        if (lvl) return;
        if (waiting) begin
          last_edge = t;
          waiting   = 1'b0;
        end else if (diff < {16'd0, deb}) begin
          bounces++;
        end else begin
          pulses++;
          avg_hz    = 32'(({32'd0, avg_hz} + {32'd0, hz_of_period(diff)}) >> 1);
          last_edge = t;
        end
      end else begin
        now_speed = {32'd0, hz_of_period(diff)} * {48'd0, mult};
        if (now_speed < 64'd16777216) begin
          waiting   = 1'b1;
          r.speed   = '0;
          r.stalled = 1'b1;
        end else begin
          spd = ({32'd0, avg_hz} * {48'd0, mult}) >> 8;
          r.speed   = (spd > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : spd[31:0];
          r.stalled = 1'b0;
        end
        r.pulse_total  = pulses;
        r.bounce_total = bounces;
        readings_q.push_back(r);
      end
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      if (mismatches < 40)
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      mismatches++;
    endtask

    task check_result(logic [31:0] speed, logic stalled, logic [31:0] pulse_total,
                      logic [31:0] bounce_total);
      reading_t want;
      if (readings_q.size() == 0) begin
        report("unexpected word", speed, 32'd0);
        return;
      end
      want = readings_q.pop_front();
      if (speed !== want.speed) report("speed", speed, want.speed);
      if (stalled !== want.stalled) report("stalled", {31'd0, stalled}, {31'd0, want.stalled});
      if (pulse_total !== want.pulse_total)
        report("pulse_total", pulse_total, want.pulse_total);
      if (bounce_total !== want.bounce_total)
        report("bounce_total", bounce_total, want.bounce_total);
    endtask

    function int unsigned pending();
      return readings_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pra_in_if  in_if ();
  pra_out_if out_if ();

  pulse_rate_anemometer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  anemo_scoreboard sb;

  // sender burst bookkeeping and the running microsecond clock of the stimulus
  int unsigned burst_left;
  logic [31:0] stim_us;

  // receiver stall pattern and the cycle count that picks its bit
  logic [12:0] stall_pat;
  int unsigned rx_cyc;

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: ready follows a repeating 13-bit pattern; windows of full speed, random
  // stalls, light stalls and long stalls (ready once per pattern) take turns
  always @(negedge clk_i) begin
    if (rx_cyc % 300 == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = 13'($urandom());
        2:       stall_pat = 13'h0001;
        default: stall_pat = 13'($urandom()) | 13'h1555;
      endcase
    end
    out_if.ready = stall_pat[rx_cyc % 13];
    rx_cyc++;
  end

  // every word taken at a rising edge goes straight to the checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.speed, out_if.stalled, out_if.pulse_total, out_if.bounce_total);
  end

  // presents one input word from a falling edge and returns at the falling edge
  // after its acceptance, valid still high so the next word can follow at once
  task automatic push_word(logic op, logic [31:0] t, logic lvl);
    if (burst_left == 0) begin
      // gap between bursts, then a new burst length (now and then a long one)
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 20);
    end
    in_if.valid     = 1'b1;
    in_if.op        = op;
    in_if.time_us   = t;
    in_if.pin_level = lvl;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(op, t, lvl);
    burst_left--;
    @(negedge clk_i);
  endtask

  // sender holds off until every expected word is back, then lets the
  // sequencer finish any pin event still in flight
  task automatic drain(int unsigned settle);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // two-phase apb write; block must be idle
  task automatic reg_write(logic sel, logic [15:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = {16'd0, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (pready) sb.set_reg(sel, val);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(logic [15:0] mult, logic [15:0] deb);
    drain(60);
    reg_write(REG_SPEED_MULT, mult);
    reg_write(REG_DEBOUNCE, deb);
  endtask

  // random phase: mostly plausible rotation traffic (edges near and past the
  // debounce time, bounces, queries), some stall-forcing long pauses and noise
  task automatic run_random(int unsigned count);
    int unsigned done;
    int unsigned pick;
    logic [31:0] dt;
    done    = 0;
    stim_us = $urandom();
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        case ($urandom_range(0, 3))
          0:       dt = $urandom_range(0, {16'd0, sb.deb});
          1, 2:    dt = {16'd0, sb.deb} + $urandom_range(0, 5000);
          default: dt = $urandom_range(0, 200000);
        endcase
        stim_us += dt;
        push_word(OP_PIN, stim_us, 1'b0);
        done++;
      end else if (pick < 60) begin
        // rising edges are ignored by the block and not counted
        stim_us += $urandom_range(0, 400);
        push_word(OP_PIN, stim_us, 1'b1);
      end else if (pick < 90) begin
        stim_us += $urandom_range(0, 3000);
        push_word(OP_QUERY, stim_us, 1'($urandom_range(0, 1)));
        done++;
      end else if (pick < 95) begin
        // long calm, usually a stall and re-arm
        stim_us += $urandom_range(100000, 300000000);
        push_word(OP_QUERY, stim_us, 1'($urandom_range(0, 1)));
        done++;
      end else begin
        push_word(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
        done++;
      end
      if (done == count / 2 && pick < 60) drain(0);
    end
  endtask

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.op        = OP_PIN;
    in_if.time_us   = '0;
    in_if.pin_level = 1'b1;
    out_if.ready    = 1'b0;
    stall_pat       = '1;
    rx_cyc          = 0;
    burst_left      = 0;
    stim_us         = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // reset defaults: multiplier 1.0, debounce 500 us
    push_word(OP_QUERY, 32'd0, 1'b0);           // query while waiting, zero elapsed
    push_word(OP_PIN, 32'd50, 1'b1);            // rising edge, no effect
    push_word(OP_PIN, 32'd1000, 1'b0);          // arming edge
    push_word(OP_PIN, 32'd1499, 1'b0);          // bounce, one short of debounce
    push_word(OP_PIN, 32'd1500, 1'b0);          // exactly the debounce time
    push_word(OP_QUERY, 32'd1600, 1'b1);
    push_word(OP_PIN, 32'd2100, 1'b0);
    push_word(OP_QUERY, 32'd2200, 1'b0);
    push_word(OP_QUERY, 32'd2000000, 1'b0);     // long calm, stall and re-arm
    push_word(OP_PIN, 32'hFFFF_FF00, 1'b0);     // arm just before the wrap
    push_word(OP_PIN, 32'h0000_0300, 1'b0);     // period across the wrap
    push_word(OP_QUERY, 32'h0000_0400, 1'b1);
    push_word(OP_PIN, 32'hFFFF_FFFF, 1'b1);
    push_word(OP_QUERY, 32'hFFFF_FFFF, 1'b1);
    run_random(150);

    // zero multiplier, no debounce
    set_config(16'd0, 16'd0);
    push_word(OP_PIN, 32'h8000_0000, 1'b0);     // arm
    push_word(OP_PIN, 32'h8000_0000, 1'b0);     // zero period, saturated rate
    push_word(OP_QUERY, 32'h8000_0000, 1'b0);   // zero multiplier always stalls
    push_word(OP_PIN, 32'h8000_0003, 1'b0);     // arm again
    push_word(OP_PIN, 32'h8000_0007, 1'b0);     // period below the divide range
    push_word(OP_QUERY, 32'h8000_0008, 1'b1);
    run_random(100);

    // largest multiplier, speed saturates on fast rotation
    set_config(16'hFFFF, 16'd0);
    push_word(OP_PIN, 32'h0000_1000, 1'b0);
    push_word(OP_PIN, 32'h0000_1001, 1'b0);
    push_word(OP_PIN, 32'h0000_1002, 1'b0);
    push_word(OP_QUERY, 32'h0000_1002, 1'b0);
    run_random(150);

    // smallest nonzero multiplier, longest debounce
    set_config(16'd1, 16'hFFFF);
    run_random(100);

    repeat (2) begin
      set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3000)));
      run_random(100);
    end

    drain(60);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
